FILE: rtl/core/nnt_pkg.sv
// Shared constants, types and helpers for the nearest-neighbor tour block.
package nnt_pkg;

  localparam int MAX_CITIES  = 16;
  localparam int CITY_BITS   = $clog2(MAX_CITIES);
  localparam int ADDR_BITS   = 2 * CITY_BITS;
  localparam int STORE_DEPTH = MAX_CITIES * MAX_CITIES;
  localparam int WEIGHT_BITS = 16;
  localparam int COUNT_BITS  = 5;
  localparam int COST_BITS   = 21;

  localparam logic [COST_BITS-1:0]  COST_MAX       = {COST_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CITY_COUNT_RST = COUNT_BITS'(MAX_CITIES);
  localparam logic [COUNT_BITS-1:0] CITY_COUNT_MIN = COUNT_BITS'(2);
  localparam logic [CITY_BITS-1:0]  HOME_CITY      = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_DRAIN,
    ST_STEP,
    ST_CLOSE_RD,
    ST_CLOSE_ADD,
    ST_CLOSE_OUT
  } walk_state_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_BITS-1:0]  addr;
    logic [WEIGHT_BITS-1:0] data;
  } store_wr_t;

  function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                   input logic [WEIGHT_BITS-1:0] b);
    logic [COST_BITS:0] s;
    s = {1'b0, a} + {{(COST_BITS + 1 - WEIGHT_BITS){1'b0}}, b};
    return s[COST_BITS] ? COST_MAX : s[COST_BITS-1:0];
  endfunction

endpackage

FILE: rtl/core/nnt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nnt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/nnt_walk.sv
// Tour sequencer: scans distance rows, picks the nearest unvisited city, drives results.
module nnt_walk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [nnt_pkg::COUNT_BITS-1:0]  n_cities,
  output logic                          busy,
  output logic [nnt_pkg::ADDR_BITS-1:0]   rd_addr,
  input  logic [nnt_pkg::WEIGHT_BITS-1:0] rd_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [nnt_pkg::CITY_BITS-1:0]   out_city,
  output logic [nnt_pkg::COST_BITS-1:0]   out_tour_cost,
  output logic                          out_last_city
);
  import nnt_pkg::*;

  walk_state_t state_r, state_nxt;

  logic [CITY_BITS-1:0]   cur_r, cur_nxt;
  logic [MAX_CITIES-1:0]  visited_r, visited_nxt;
  logic [COST_BITS-1:0]   cost_r, cost_nxt;
  logic [COUNT_BITS-1:0]  step_r, step_nxt;
  logic [CITY_BITS-1:0]   scan_r, scan_nxt;
  logic                   pend_r;
  logic [CITY_BITS-1:0]   pend_idx_r;
  logic                   found_r, found_nxt;
  logic [CITY_BITS-1:0]   best_r, best_nxt;
  logic [WEIGHT_BITS-1:0] best_w_r, best_w_nxt;

  logic                   out_valid_r;
  logic [CITY_BITS-1:0]   out_city_r;
  logic [COST_BITS-1:0]   out_cost_r;
  logic                   out_last_r;

  logic                   slot_free;
  logic                   scan_done;
  logic                   last_step;
  logic                   push;
  logic                   rd_issue;
  logic [CITY_BITS-1:0]   push_city;
  logic [COST_BITS-1:0]   push_cost;
  logic                   push_last;
  logic                   take;

  assign slot_free = !out_valid_r || !out_stall;
  assign scan_done = ({1'b0, scan_r} == (n_cities - COUNT_BITS'(1)));
  assign last_step = ((step_r + COUNT_BITS'(1)) == n_cities);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_FIRST;
      end
      ST_FIRST: begin
        if (slot_free) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_STEP;
      ST_STEP: begin
        if (slot_free) state_nxt = last_step ? ST_CLOSE_RD : ST_SCAN;
      end
      ST_CLOSE_RD:  state_nxt = ST_CLOSE_ADD;
      ST_CLOSE_ADD: state_nxt = ST_CLOSE_OUT;
      ST_CLOSE_OUT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != ST_IDLE);
    rd_issue  = 1'b0;
    rd_addr   = {cur_r, scan_r};
    push      = 1'b0;
    push_city = HOME_CITY;
    push_cost = '0;
    push_last = 1'b0;
    case (state_r)
      ST_FIRST: push = slot_free;
      ST_SCAN:  rd_issue = 1'b1;
      ST_STEP: begin
        push      = slot_free;
        push_city = best_r;
      end
      ST_CLOSE_RD: rd_addr = {cur_r, HOME_CITY};
      ST_CLOSE_OUT: begin
        push      = slot_free;
        push_cost = cost_r;
        push_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign take = pend_r && !visited_r[pend_idx_r] && (!found_r || (rd_data < best_w_r));

  always_comb begin
    cur_nxt     = cur_r;
    visited_nxt = visited_r;
    cost_nxt    = cost_r;
    step_nxt    = step_r;
    scan_nxt    = scan_r;
    found_nxt   = found_r;
    best_nxt    = best_r;
    best_w_nxt  = best_w_r;
    if (take) begin
      found_nxt  = 1'b1;
      best_nxt   = pend_idx_r;
      best_w_nxt = rd_data;
    end
    if (rd_issue) scan_nxt = scan_r + CITY_BITS'(1);
    case (state_r)
      ST_FIRST: begin
        if (slot_free) begin
          cur_nxt     = HOME_CITY;
          visited_nxt = MAX_CITIES'(1);
          cost_nxt    = '0;
          step_nxt    = COUNT_BITS'(1);
          scan_nxt    = '0;
          found_nxt   = 1'b0;
        end
      end
      ST_STEP: begin
        if (slot_free) begin
          cost_nxt              = sat_add(cost_r, best_w_r);
          cur_nxt               = best_r;
          visited_nxt[best_r]   = 1'b1;
          step_nxt              = step_r + COUNT_BITS'(1);
          scan_nxt              = '0;
          found_nxt             = 1'b0;
        end
      end
      ST_CLOSE_ADD: begin
        cost_nxt = sat_add(cost_r, rd_data);
        cur_nxt  = HOME_CITY;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      visited_r   <= '0;
      cost_r      <= '0;
      step_r      <= '0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      visited_r   <= visited_nxt;
      cost_r      <= cost_nxt;
      step_r      <= step_nxt;
      scan_r      <= scan_nxt;
      pend_r      <= rd_issue;
      found_r     <= found_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= scan_r;
    best_r     <= best_nxt;
    best_w_r   <= best_w_nxt;
    if (push) begin
      out_city_r <= push_city;
      out_cost_r <= push_cost;
      out_last_r <= push_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_city      = out_city_r;
  assign out_tour_cost = out_cost_r;
  assign out_last_city = out_last_r;

endmodule

FILE: rtl/core/nearest_neighbor_tour.sv
// Nearest-neighbor tour block: every input transaction writes one entry of the
// 16x16 distance store. A transaction with start_req set is stored and then
// launches a greedy tour from city 0 over city_count cities; the block stalls
// its input until the closing result is in the output register. The tour emits
// city 0, each chosen city, and a closing city 0 with last_city and the
// saturated total cost. Each step sweeps one row of the store through its
// single read port, one entry per cycle. The user must write city_count through
// the cfg port only while no tour is running; the block does not enforce this.
// Values are clamped to 2..16.
module nearest_neighbor_tour (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [nnt_pkg::CITY_BITS-1:0]   in_from_city,
  input  logic [nnt_pkg::CITY_BITS-1:0]   in_to_city,
  input  logic [nnt_pkg::WEIGHT_BITS-1:0] in_distance,
  input  logic                          in_start_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [nnt_pkg::CITY_BITS-1:0]   out_city,
  output logic [nnt_pkg::COST_BITS-1:0]   out_tour_cost,
  output logic                          out_last_city,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nnt_pkg::COUNT_BITS-1:0]  cfg_data
);
  import nnt_pkg::*;

  logic [COUNT_BITS-1:0]  city_count_r;
  logic [COUNT_BITS-1:0]  n_cities;
  logic                   busy;
  logic                   in_take;
  store_wr_t              wr;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic [WEIGHT_BITS-1:0] rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= CITY_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      city_count_r <= cfg_data;
    end
  end

  always_comb begin
    n_cities = city_count_r;
    if (city_count_r < CITY_COUNT_MIN) n_cities = CITY_COUNT_MIN;
    if (city_count_r > CITY_COUNT_RST) n_cities = CITY_COUNT_RST;
  end

  assign in_stall = busy;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    wr.we   = in_take;
    wr.addr = {in_from_city, in_to_city};
    wr.data = in_distance;
  end

  nnt_ram #(
    .WIDTH(WEIGHT_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr.we),
    .waddr(wr.addr),
    .wdata(wr.data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  nnt_walk u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_take && in_start_req),
    .n_cities     (n_cities),
    .busy         (busy),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_city     (out_city),
    .out_tour_cost(out_tour_cost),
    .out_last_city(out_last_city)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the nearest-neighbor tour block: directed rows, then random tours.
`timescale 1ns / 1ps

module tb_top;
  import nnt_pkg::*;

  localparam int  RAND_ITEMS  = 150;
  localparam int  IDLE_CYCLES = 16;
  localparam int  DRAIN_WAIT  = 50;
  localparam int  LONG_HOLD   = 400;
  localparam time LIMIT_NS    = 50_000_000;

  typedef enum logic {ROW_CFG, ROW_ENTRY} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [COUNT_BITS-1:0]  count;
    logic [CITY_BITS-1:0]   from_c;
    logic [CITY_BITS-1:0]   to_c;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   start;
    logic                   typed;
    logic [COST_BITS-1:0]   cost;
  } step_row_t;

  typedef struct packed {
    logic [CITY_BITS-1:0] city;
    logic [COST_BITS-1:0] cost;
    logic                 last;
  } tour_stop_t;

  localparam int DIR_ROWS = 24;
  localparam step_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_CFG,   5'd2,  4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd0,  4'd1,  16'hFFFF, 1'b0, 1'b0, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd1,  4'd0,  16'hFFFF, 1'b1, 1'b1, 21'h1FFFE},
    '{ROW_ENTRY, 5'd0,  4'd0,  4'd1,  16'h0000, 1'b0, 1'b0, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd1,  4'd0,  16'h0000, 1'b1, 1'b1, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd1,  4'd1,  16'hABCD, 1'b1, 1'b1, 21'd0},
    '{ROW_CFG,   5'd0,  4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd0,  4'd1,  16'd5,    1'b1, 1'b1, 21'd5},
    '{ROW_CFG,   5'd1,  4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd1,  4'd0,  16'd7,    1'b1, 1'b1, 21'd12},
    '{ROW_CFG,   5'd3,  4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd0,  4'd2,  16'd5,    1'b0, 1'b0, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd1,  4'd2,  16'd9,    1'b0, 1'b0, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd2,  4'd0,  16'd3,    1'b0, 1'b0, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd2,  4'd1,  16'd4,    1'b1, 1'b0, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd0,  4'd2,  16'd1,    1'b1, 1'b0, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd2,  4'd2,  16'h0000, 1'b1, 1'b0, 21'd0},
    '{ROW_CFG,   5'd31, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd15, 4'd15, 16'hFFFF, 1'b1, 1'b0, 21'd0},
    '{ROW_CFG,   5'd16, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd15, 4'd0,  16'h0000, 1'b1, 1'b0, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd0,  4'd15, 16'h0000, 1'b1, 1'b0, 21'd0},
    '{ROW_CFG,   5'd17, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 21'd0},
    '{ROW_ENTRY, 5'd0,  4'd3,  4'd4,  16'h8000, 1'b1, 1'b0, 21'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [CITY_BITS-1:0]   in_from_city;
  logic [CITY_BITS-1:0]   in_to_city;
  logic [WEIGHT_BITS-1:0] in_distance;
  logic                   in_start_req;
  logic                   out_valid;
  logic                   out_stall;
  logic [CITY_BITS-1:0]   out_city;
  logic [COST_BITS-1:0]   out_tour_cost;
  logic                   out_last_city;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [COUNT_BITS-1:0]  cfg_data;

  logic [WEIGHT_BITS-1:0] weight_mem [MAX_CITIES][MAX_CITIES];
  logic [MAX_CITIES-1:0]  written_mask [MAX_CITIES];
  logic [COUNT_BITS-1:0]  city_count_r;
  tour_stop_t             stop_q [$];

  int errors   = 0;
  int n_loads  = 0;
  int n_tours  = 0;
  int n_got    = 0;
  int n_cfg    = 0;
  bit held_long = 1'b0;

  nearest_neighbor_tour u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_from_city  (in_from_city),
    .in_to_city    (in_to_city),
    .in_distance   (in_distance),
    .in_start_req  (in_start_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_city      (out_city),
    .out_tour_cost (out_tour_cost),
    .out_last_city (out_last_city),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic int cities_active();
    if (city_count_r < CITY_COUNT_MIN) return 2;
    if (city_count_r > MAX_CITIES) return MAX_CITIES;
    return int'(city_count_r);
  endfunction

  function automatic logic [COST_BITS:0] cost_plus(input logic [COST_BITS:0] acc,
                                                   input logic [WEIGHT_BITS-1:0] w);
    logic [COST_BITS:0] s;
    s = acc + w;
    return (s > COST_MAX) ? {1'b0, COST_MAX} : s;
  endfunction

  function automatic void push_stop(input logic [CITY_BITS-1:0] c,
                                    input logic [COST_BITS-1:0] cost, input logic last);
    tour_stop_t s;
    s.city = c;
    s.cost = cost;
    s.last = last;
    stop_q.insert(stop_q.size(), s);
  endfunction

  function automatic void predict_tour();
    int                     n;
    bit                     found;
    logic [MAX_CITIES-1:0]  visited;
    logic [CITY_BITS-1:0]   here;
    logic [CITY_BITS-1:0]   best;
    logic [WEIGHT_BITS-1:0] best_w;
    logic [COST_BITS:0]     sum;
    n = cities_active();
    visited = MAX_CITIES'(1);
    here = HOME_CITY;
    sum = '0;
    best = '0;
    best_w = '0;
    push_stop(HOME_CITY, '0, 1'b0);
    for (int step = 1; step < n; step++) begin
      found = 1'b0;
      for (int c = 0; c < n; c++) begin
        if (!visited[c] && (!found || weight_mem[here][c] < best_w)) begin
          found = 1'b1;
          best = CITY_BITS'(c);
          best_w = weight_mem[here][c];
        end
      end
      sum = cost_plus(sum, best_w);
      here = best;
      visited[best] = 1'b1;
      push_stop(best, '0, 1'b0);
    end
    sum = cost_plus(sum, weight_mem[here][HOME_CITY]);
    push_stop(HOME_CITY, sum[COST_BITS-1:0], 1'b1);
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2, 3:    return WEIGHT_BITS'($urandom_range(0, 7));
      default: return WEIGHT_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [COUNT_BITS-1:0] pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return COUNT_BITS'($urandom_range(2, 5));
    if (r < 16) return COUNT_BITS'($urandom_range(0, 1));
    return COUNT_BITS'($urandom_range(6, 31));
  endfunction

  task automatic send_entry(input logic [CITY_BITS-1:0] f, input logic [CITY_BITS-1:0] t,
                            input logic [WEIGHT_BITS-1:0] w, input logic s,
                            input logic typed, input logic [COST_BITS-1:0] cost);
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_from_city <= f;
    in_to_city   <= t;
    in_distance  <= w;
    in_start_req <= s;
    do @(posedge clk); while (in_stall);
    weight_mem[f][t] = w;
    written_mask[f][t] = 1'b1;
    n_loads++;
    if (s) begin
      n_tours++;
      if (typed) begin
        push_stop(HOME_CITY, '0, 1'b0);
        push_stop(CITY_BITS'(1), '0, 1'b0);
        push_stop(HOME_CITY, cost, 1'b1);
      end else begin
        predict_tour();
      end
    end
  endtask

  // load every not-yet-written off-diagonal entry the coming tour may read, except the one the start writes
  task automatic fill_missing(input logic [CITY_BITS-1:0] f, input logic [CITY_BITS-1:0] t);
    int n;
    n = cities_active();
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (r != c && !written_mask[r][c] && !(r == f && c == t))
          send_entry(CITY_BITS'(r), CITY_BITS'(c), pick_weight(), 1'b0, 1'b0, '0);
      end
    end
  endtask

  task automatic write_city_count(input logic [COUNT_BITS-1:0] v);
    in_valid <= 1'b0;
    while (stop_q.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    city_count_r = v;
    n_cfg++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_got++;
      if (stop_q.size() == 0) begin
        report_mismatch($sformatf("unexpected city %0d", out_city));
      end else begin
        tour_stop_t want;
        want = stop_q.pop_front();
        if (out_city !== want.city)
          report_mismatch($sformatf("city %0d, want %0d", out_city, want.city));
        if (out_tour_cost !== want.cost)
          report_mismatch($sformatf("tour_cost %0d, want %0d", out_tour_cost, want.cost));
        if (out_last_city !== want.last)
          report_mismatch($sformatf("last_city %0b, want %0b", out_last_city, want.last));
      end
    end
  end

  initial begin
    int  run_left;
    bit  stall_now;
    run_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_long && n_got >= 40 && out_valid) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        stall_now = ($urandom_range(0, 2) == 0);
        out_stall <= stall_now;
        run_left = stall_now ? idle_len() : $urandom_range(0, 30);
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results outstanding", stop_q.size());
    $display("[nearest_neighbor_tour] ERROR");
    $finish;
  end

  initial begin
    logic [CITY_BITS-1:0]   f;
    logic [CITY_BITS-1:0]   t;
    logic                   s;
    step_row_t              row;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_from_city <= '0;
    in_to_city   <= '0;
    in_distance  <= '0;
    in_start_req <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    city_count_r = CITY_COUNT_RST;
    for (int r = 0; r < MAX_CITIES; r++) written_mask[r] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      if (row.kind == ROW_CFG) begin
        write_city_count(row.count);
      end else begin
        if (row.start) fill_missing(row.from_c, row.to_c);
        send_entry(row.from_c, row.to_c, row.weight, row.start, row.typed, row.cost);
      end
    end

    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 40 == 0) write_city_count(pick_count());
      f = CITY_BITS'($urandom);
      t = CITY_BITS'($urandom);
      s = ($urandom_range(0, 6) == 0);
      if (s) fill_missing(f, t);
      send_entry(f, t, pick_weight(), s, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (stop_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d entry loads and %0d tours over %0d city_count settings",
             n_loads, n_tours, n_cfg);
    $display("checked %0d tour results, long output hold %0s", n_got,
             held_long ? "applied" : "not reached");
    if (errors == 0) begin
      $display("[nearest_neighbor_tour] OK");
    end else begin
      $display("[nearest_neighbor_tour] ERROR");
    end
    $finish;
  end

endmodule
